// ===== sv/sme_pkg.sv =====
// Package: sizes, opcodes and fault codes of the stack machine execute unit
`timescale 1ns / 1ps
package sme_pkg;

  // Storage sizes
  localparam int STACK_DEPTH   = 128;
  localparam int DATA_WORDS    = 1024;
  localparam int PROGRAM_WORDS = 1024;

  // Derived widths
  localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int SADDR_W   = $clog2(STACK_DEPTH);
  localparam int DADDR_W   = $clog2(DATA_WORDS);
  localparam int PC_W      = $clog2(PROGRAM_WORDS);
  localparam int WORD_W    = 32;
  localparam int CMD_W     = 4;
  localparam int NEXT_PC_W = 10;
  localparam int FAULT_W   = 2;

  // Instruction opcodes
  typedef enum logic [CMD_W-1:0] {
    CMD_POP   = 4'd0,
    CMD_LOADC = 4'd1,
    CMD_LOAD  = 4'd2,
    CMD_STORE = 4'd3,
    CMD_ADD   = 4'd4,
    CMD_SUB   = 4'd5,
    CMD_MUL   = 4'd6,
    CMD_LESS  = 4'd7,
    CMD_EQUAL = 4'd8,
    CMD_JUMP  = 4'd9,
    CMD_JUMPZ = 4'd10,
    CMD_PRINT = 4'd11,
    CMD_EXIT  = 4'd12
  } cmd_t;

  // Fault codes
  typedef enum logic [FAULT_W-1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_STACK = 2'd1,
    FAULT_ADDR  = 2'd2
  } fault_t;

endpackage

// ===== sv/stack_machine_execute_top.sv =====
// Top level: stack machine execute unit with operand stack and data memory
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------------
//   in_     | input     | in_valid / in_stall | command, operand
//   out_    | output    | out_valid/out_stall | next_pc, print_valid, print_value,
//           |           |                    | halted, fault
//
// One instruction per cycle unless a stalled result or the clearing pass holds it up: an
// accepted instruction executes from the input register once the result register is free
// to take its result, which is registered at the next edge. The top two stack entries live
// in registers; the stack memory and the data memory are read every cycle at the addresses
// the new state needs, so their registered read data is ready for the next instruction.
// After reset the data memory is cleared one word a cycle, during which in_stall is high.
// A stalled result holds the executing instruction in the input register; a new transaction
// is still taken while the input register is free.
`timescale 1ns / 1ps
module stack_machine_execute_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [sme_pkg::CMD_W-1:0]            in_command,
  input  logic signed [sme_pkg::WORD_W-1:0]    in_operand,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [sme_pkg::NEXT_PC_W-1:0]        out_next_pc,
  output logic                                 out_print_valid,
  output logic signed [sme_pkg::WORD_W-1:0]    out_print_value,
  output logic                                 out_halted,
  output logic [sme_pkg::FAULT_W-1:0]          out_fault
);
  import sme_pkg::*;

  // Input register
  logic                 vld_r;
  logic [CMD_W-1:0]     cmd_r;
  logic [WORD_W-1:0]    opd_r;

  // Architectural state
  logic [CNT_W-1:0]     cnt_r,  cnt_nxt;
  logic [WORD_W-1:0]    top_r,  top_nxt;
  logic [WORD_W-1:0]    sec_r,  sec_nxt;
  logic [PC_W-1:0]      pc_r,   pc_nxt;
  logic                 halt_r, halt_nxt;

  // Data memory clearing pass
  logic                 clr_busy_r;
  logic [DADDR_W-1:0]   clr_addr_r;

  // Result register
  logic                 out_valid_r;
  logic [PC_W-1:0]      res_pc_r;
  logic                 res_pvalid_r, res_pvalid_nxt;
  logic [WORD_W-1:0]    res_pvalue_r, res_pvalue_nxt;
  logic                 res_halted_r;
  fault_t               res_fault_r,  res_fault_nxt;

  // Stack memory (entries below the two cached ones)
  logic [WORD_W-1:0]    stack_mem [STACK_DEPTH];
  logic                 st_we;
  logic [SADDR_W-1:0]   st_waddr, st_raddr;
  logic [WORD_W-1:0]    st_rdata_r, st_bdata_r;
  logic                 st_byp_r;
  logic [WORD_W-1:0]    third;

  // Data memory
  logic [WORD_W-1:0]    data_mem [DATA_WORDS];
  logic                 dm_we, store_we;
  logic [DADDR_W-1:0]   dm_waddr, dm_raddr;
  logic [WORD_W-1:0]    dm_wdata;
  logic [WORD_W-1:0]    dm_rdata_r, dm_bdata_r;
  logic                 dm_byp_r;
  logic [WORD_W-1:0]    dm_word;

  // Execute stage helpers
  logic                 fire, accept;
  logic [PC_W-1:0]      pc_adv;
  logic [1:0]           need;
  fault_t               flt;
  logic                 top_ok, sec_ok, opd_ok, top_zero;
  logic [WORD_W-1:0]    alu_res;
  logic [CNT_W-1:0]     cnt_m2, cnt_nxt_m3;

  // Handshake
  assign fire     = vld_r && !clr_busy_r && (!out_valid_r || !out_stall);
  assign in_stall = clr_busy_r || (vld_r && !fire);
  assign accept   = in_valid && !in_stall;

  // Memory read data with same-cycle write bypass
  assign third   = st_byp_r ? st_bdata_r : st_rdata_r;
  assign dm_word = dm_byp_r ? dm_bdata_r : dm_rdata_r;

  // Operand checks
  assign top_ok   = !top_r[WORD_W-1] && (top_r < WORD_W'(DATA_WORDS));
  assign sec_ok   = !sec_r[WORD_W-1] && (sec_r < WORD_W'(DATA_WORDS));
  assign opd_ok   = !opd_r[WORD_W-1] && (opd_r < WORD_W'(PROGRAM_WORDS));
  assign top_zero = (top_r == '0);
  assign pc_adv   = (pc_r == PC_W'(PROGRAM_WORDS - 1)) ? '0 : pc_r + PC_W'(1);

  // ALU: second operand is the left one
  always_comb begin
    case (cmd_r)
      CMD_ADD:   alu_res = sec_r + top_r;
      CMD_SUB:   alu_res = sec_r - top_r;
      CMD_MUL:   alu_res = sec_r * top_r;
      CMD_LESS:  alu_res = ($signed(sec_r) < $signed(top_r)) ? WORD_W'(1) : '0;
      CMD_EQUAL: alu_res = (sec_r == top_r) ? WORD_W'(1) : '0;
      default:   alu_res = '0;
    endcase
  end

  // Fault detection: stack checks first, then address checks
  always_comb begin
    need = 2'd0;
    if (cmd_r inside {CMD_POP, CMD_LOAD, CMD_JUMPZ, CMD_PRINT}) begin
      need = 2'd1;
    end else if (cmd_r inside {CMD_STORE, CMD_ADD, CMD_SUB, CMD_MUL, CMD_LESS,
                               CMD_EQUAL}) begin
      need = 2'd2;
    end
    flt = FAULT_NONE;
    if ((cnt_r < CNT_W'(need)) ||
        (cmd_r == CMD_LOADC && cnt_r >= CNT_W'(STACK_DEPTH))) begin
      flt = FAULT_STACK;
    end else begin
      case (cmd_r)
        CMD_LOAD:  if (!top_ok) flt = FAULT_ADDR;
        CMD_STORE: if (!sec_ok) flt = FAULT_ADDR;
        CMD_JUMP:  if (!opd_ok) flt = FAULT_ADDR;
        CMD_JUMPZ: if (top_zero && !opd_ok) flt = FAULT_ADDR;
        default:   flt = FAULT_NONE;
      endcase
    end
  end

  // Execute: next state and result
  always_comb begin
    cnt_nxt        = cnt_r;
    top_nxt        = top_r;
    sec_nxt        = sec_r;
    pc_nxt         = pc_r;
    halt_nxt       = halt_r;
    st_we          = 1'b0;
    store_we       = 1'b0;
    res_pvalid_nxt = 1'b0;
    res_pvalue_nxt = '0;
    res_fault_nxt  = FAULT_NONE;
    if (fire && !halt_r) begin
      if (flt != FAULT_NONE) begin
        res_fault_nxt = flt;
      end else begin
        pc_nxt = pc_adv;
        case (cmd_r)
          CMD_POP: begin
            top_nxt = sec_r;
            sec_nxt = third;
            cnt_nxt = cnt_r - CNT_W'(1);
          end
          CMD_LOADC: begin
            st_we   = (cnt_r >= CNT_W'(2));
            top_nxt = opd_r;
            sec_nxt = top_r;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          CMD_LOAD: begin
            top_nxt = dm_word;
          end
          CMD_STORE: begin
            store_we = 1'b1;
            top_nxt  = sec_r;
            sec_nxt  = third;
            cnt_nxt  = cnt_r - CNT_W'(1);
          end
          CMD_ADD, CMD_SUB, CMD_MUL, CMD_LESS, CMD_EQUAL: begin
            top_nxt = alu_res;
            sec_nxt = third;
            cnt_nxt = cnt_r - CNT_W'(1);
          end
          CMD_JUMP: begin
            pc_nxt = opd_r[PC_W-1:0];
          end
          CMD_JUMPZ: begin
            if (top_zero) pc_nxt = opd_r[PC_W-1:0];
            top_nxt = sec_r;
            sec_nxt = third;
            cnt_nxt = cnt_r - CNT_W'(1);
          end
          CMD_PRINT: begin
            res_pvalid_nxt = 1'b1;
            res_pvalue_nxt = top_r;
          end
          CMD_EXIT: begin
            halt_nxt = 1'b1;
          end
          default: begin
            pc_nxt = pc_adv;
          end
        endcase
      end
    end
  end

  // Memory addressing
  assign cnt_m2     = cnt_r - CNT_W'(2);
  assign cnt_nxt_m3 = cnt_nxt - CNT_W'(3);
  assign st_waddr   = cnt_m2[SADDR_W-1:0];
  assign st_raddr   = cnt_nxt_m3[SADDR_W-1:0];
  assign dm_we      = clr_busy_r || store_we;
  assign dm_waddr   = clr_busy_r ? clr_addr_r : sec_r[DADDR_W-1:0];
  assign dm_wdata   = clr_busy_r ? '0 : top_r;
  assign dm_raddr   = top_nxt[DADDR_W-1:0];

  // Stack memory: spill the second entry on push, read the new third entry
  always_ff @(posedge clk) begin
    if (st_we) begin
      stack_mem[st_waddr] <= sec_r;
    end
    st_rdata_r <= stack_mem[st_raddr];
    st_bdata_r <= sec_r;
  end

  // Data memory: clear or store, read at the new top of stack
  always_ff @(posedge clk) begin
    if (dm_we) begin
      data_mem[dm_waddr] <= dm_wdata;
    end
    dm_rdata_r <= data_mem[dm_raddr];
    dm_bdata_r <= dm_wdata;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= 1'b0;
      cnt_r       <= '0;
      pc_r        <= '0;
      halt_r      <= 1'b0;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      st_byp_r    <= 1'b0;
      dm_byp_r    <= 1'b0;
    end else begin
      vld_r    <= accept || (vld_r && !fire);
      cnt_r    <= cnt_nxt;
      pc_r     <= pc_nxt;
      halt_r   <= halt_nxt;
      st_byp_r <= st_we && (st_waddr == st_raddr);
      dm_byp_r <= dm_we && (dm_waddr == dm_raddr);
      // Sweep the data memory once after reset
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + DADDR_W'(1);
        if (clr_addr_r == DADDR_W'(DATA_WORDS - 1)) clr_busy_r <= 1'b0;
      end
      // Hold the result until taken
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_command;
      opd_r <= in_operand;
    end
    top_r <= top_nxt;
    sec_r <= sec_nxt;
    if (fire) begin
      res_pc_r     <= pc_nxt;
      res_pvalid_r <= res_pvalid_nxt;
      res_pvalue_r <= res_pvalue_nxt;
      res_halted_r <= halt_nxt;
      res_fault_r  <= res_fault_nxt;
    end
  end

  // Outputs
  assign out_valid       = out_valid_r;
  assign out_next_pc     = NEXT_PC_W'(res_pc_r);
  assign out_print_valid = res_pvalid_r;
  assign out_print_value = res_pvalue_r;
  assign out_halted      = res_halted_r;
  assign out_fault       = res_fault_r;

endmodule

// ===== tb/stack_machine_execute_top_tb.sv =====
// Testbench: self-checking stimulus, prediction and result checks for stack_machine_execute_top
`timescale 1ns / 1ps
module stack_machine_execute_top_tb;
  import sme_pkg::*;

  localparam int CLK_PERIOD     = 2;
  localparam int RESET_CYCLES   = 9;
  localparam int RANDOM_ITEMS   = 340;
  localparam int FILL_ITEMS     = 250;
  localparam int HOLDOFF_CYCLES = 150;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS    = 40;
  localparam int STACK_HIGH     = 96;
  localparam logic [CMD_W-1:0] CMD_LAST_CODE = 4'hF;

  // One expected transaction on the result channel
  typedef struct {
    logic [NEXT_PC_W-1:0] next_pc;
    logic                 print_valid;
    logic [WORD_W-1:0]    print_value;
    logic                 halted;
    fault_t               fault;
  } exec_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [CMD_W-1:0]                in_command = '0;
  logic signed [WORD_W-1:0]        in_operand = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [NEXT_PC_W-1:0]            out_next_pc;
  logic                            out_print_valid;
  logic signed [WORD_W-1:0]        out_print_value;
  logic                            out_halted;
  logic [FAULT_W-1:0]              out_fault;

  // Machine state as the testbench predicts it
  logic [WORD_W-1:0] shadow_stack [STACK_DEPTH];
  logic [WORD_W-1:0] shadow_dmem [DATA_WORDS];
  int                shadow_count = 0;
  logic [PC_W-1:0]   shadow_pc = '0;
  logic              shadow_halted = 1'b0;

  exec_result_t pending_results[$];
  int           errors = 0;
  int           instr_count = 0;
  int           idle_pct = 0;
  int           stall_pct = 0;
  int           quiet_cycles = 0;
  logic         holding_off = 1'b0;
  event         holdoff_start;

  stack_machine_execute_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_operand      (in_operand),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_next_pc     (out_next_pc),
    .out_print_valid (out_print_valid),
    .out_print_value (out_print_value),
    .out_halted      (out_halted),
    .out_fault       (out_fault)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic addr_in_range(input logic [WORD_W-1:0] v, input int limit);
    return !v[WORD_W-1] && v < limit;
  endfunction

  // Execute one instruction on the shadow state and return its result
  function automatic exec_result_t execute_instr(input logic [CMD_W-1:0] cmd,
                                                 input logic [WORD_W-1:0] opd);
    exec_result_t      r;
    int                need;
    logic [WORD_W-1:0] top, sec, res;
    logic [PC_W-1:0]   pc_next;
    fault_t            flt;
    r.next_pc     = shadow_pc;
    r.print_valid = 1'b0;
    r.print_value = '0;
    r.halted      = shadow_halted;
    r.fault       = FAULT_NONE;
    if (shadow_halted) return r;
    need    = 0;
    top     = '0;
    sec     = '0;
    res     = '0;
    flt     = FAULT_NONE;
    pc_next = (shadow_pc == PROGRAM_WORDS - 1) ? '0 : shadow_pc + 1'b1;
    case (cmd)
      CMD_POP, CMD_LOAD, CMD_JUMPZ, CMD_PRINT: need = 1;
      CMD_STORE, CMD_ADD, CMD_SUB, CMD_MUL, CMD_LESS, CMD_EQUAL: need = 2;
      default: need = 0;
    endcase
    // stack checks take priority over address checks
    if (shadow_count < need || (cmd == CMD_LOADC && shadow_count >= STACK_DEPTH)) begin
      flt = FAULT_STACK;
    end else begin
      if (need >= 1) top = shadow_stack[shadow_count - 1];
      if (need >= 2) sec = shadow_stack[shadow_count - 2];
      case (cmd)
        CMD_LOAD:  if (!addr_in_range(top, DATA_WORDS)) flt = FAULT_ADDR;
        CMD_STORE: if (!addr_in_range(sec, DATA_WORDS)) flt = FAULT_ADDR;
        CMD_JUMP:  if (!addr_in_range(opd, PROGRAM_WORDS)) flt = FAULT_ADDR;
        CMD_JUMPZ: if (top == '0 && !addr_in_range(opd, PROGRAM_WORDS)) flt = FAULT_ADDR;
        default: ;
      endcase
    end
    // a faulting instruction leaves all state alone
    if (flt != FAULT_NONE) begin
      r.fault = flt;
      return r;
    end
    case (cmd)
      CMD_POP: shadow_count--;
      CMD_LOADC: begin
        shadow_stack[shadow_count] = opd;
        shadow_count++;
      end
      CMD_LOAD: shadow_stack[shadow_count - 1] = shadow_dmem[top[DADDR_W-1:0]];
      CMD_STORE: begin
        shadow_dmem[sec[DADDR_W-1:0]] = top;
        shadow_count--;
      end
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_LESS, CMD_EQUAL: begin
        case (cmd)
          CMD_ADD: res = sec + top;
          CMD_SUB: res = sec - top;
          CMD_MUL: res = sec * top;
          CMD_LESS: res = ($signed(sec) < $signed(top)) ? 32'd1 : 32'd0;
          default: res = (sec == top) ? 32'd1 : 32'd0;
        endcase
        shadow_count--;
        shadow_stack[shadow_count - 1] = res;
      end
      CMD_JUMP: pc_next = opd[PC_W-1:0];
      CMD_JUMPZ: begin
        if (top == '0) pc_next = opd[PC_W-1:0];
        shadow_count--;
      end
      CMD_PRINT: begin
        r.print_valid = 1'b1;
        r.print_value = top;
      end
      CMD_EXIT: shadow_halted = 1'b1;
      default: ;
    endcase
    shadow_pc = pc_next;
    r.next_pc = shadow_pc;
    r.halted  = shadow_halted;
    return r;
  endfunction

  // Random operand: extremes, small values and full-range words
  function automatic logic [WORD_W-1:0] rand_word();
    logic [WORD_W-1:0] corners [5];
    corners = '{32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
    case ($urandom_range(3))
      0: return 32'($urandom_range(16)) - 32'd8;
      1: return corners[$urandom_range(4)];
      default: return $urandom();
    endcase
  endfunction

  // Random data address: mostly a few hot words, some anywhere, some out of range
  function automatic logic [WORD_W-1:0] rand_addr();
    int r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(15);
    if (r < 85) return $urandom_range(DATA_WORDS - 1);
    return rand_word();
  endfunction

  function automatic logic [WORD_W-1:0] rand_target();
    if ($urandom_range(99) < 85) return $urandom_range(PROGRAM_WORDS - 1);
    return rand_word();
  endfunction

  // Offer one instruction, hold it until accepted, then record its expected result
  task automatic send_instr(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] opd);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_operand <= opd;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pending_results.push_back(execute_instr(cmd, opd));
    instr_count++;
  endtask

  // Drop valid and hold until every expected result has arrived
  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Issue one short well-formed program fragment, or noise
  task automatic send_sequence();
    int          kind;
    logic [CMD_W-1:0] cmd;
    kind = $urandom_range(99);
    if (shadow_count > STACK_HIGH) begin
      repeat ($urandom_range(1, STACK_HIGH)) send_instr(CMD_POP, rand_word());
    end else if (kind < 12) begin
      // memory write, then drop the address
      send_instr(CMD_LOADC, rand_addr());
      send_instr(CMD_LOADC, rand_word());
      send_instr(CMD_STORE, rand_word());
      send_instr(CMD_POP, rand_word());
    end else if (kind < 24) begin
      // memory read and show it
      send_instr(CMD_LOADC, rand_addr());
      send_instr(CMD_LOAD, rand_word());
      send_instr(CMD_PRINT, rand_word());
    end else if (kind < 50) begin
      send_instr(CMD_LOADC, rand_word());
      send_instr(CMD_LOADC, rand_word());
      send_instr(CMD_W'($urandom_range(CMD_ADD, CMD_EQUAL)), rand_word());
      send_instr(CMD_PRINT, rand_word());
    end else if (kind < 58) begin
      send_instr(CMD_JUMP, rand_target());
    end else if (kind < 66) begin
      send_instr(CMD_LOADC, ($urandom_range(1) == 0) ? '0 : rand_word());
      send_instr(CMD_JUMPZ, rand_target());
    end else if (kind < 74) begin
      send_instr(CMD_POP, rand_word());
    end else if (kind < 82) begin
      send_instr(CMD_PRINT, rand_word());
    end else begin
      // any opcode, spare ones included, exit kept for the end
      cmd = CMD_W'($urandom_range(CMD_LAST_CODE));
      if (cmd == CMD_EXIT) cmd = CMD_POP;
      send_instr(cmd, ($urandom_range(1) == 0) ? rand_addr() : rand_word());
    end
  endtask

  task automatic test_stack_faults();
    send_instr(CMD_POP, 32'h0);
    send_instr(CMD_JUMPZ, 32'h5);
    send_instr(CMD_PRINT, 32'hFFFF_FFFF);
    send_instr(CMD_ADD, 32'h0);
    send_instr(CMD_LOADC, 32'h7FFF_FFFF);
    send_instr(CMD_STORE, 32'h0);
  endtask

  task automatic test_alu_ops();
    // wrap on add and multiply, signed compare, second minus top
    send_instr(CMD_LOADC, 32'h1);
    send_instr(CMD_ADD, 32'h0);
    send_instr(CMD_PRINT, 32'h0);
    send_instr(CMD_LOADC, 32'hFFFF_FFFF);
    send_instr(CMD_MUL, 32'h0);
    send_instr(CMD_LOADC, 32'h5);
    send_instr(CMD_LESS, 32'h0);
    send_instr(CMD_LOADC, 32'h1);
    send_instr(CMD_EQUAL, 32'h0);
    send_instr(CMD_LOADC, 32'h3);
    send_instr(CMD_SUB, 32'h0);
    send_instr(CMD_PRINT, 32'h0);
    send_instr(CMD_POP, 32'h0);
  endtask

  task automatic test_memory_access();
    send_instr(CMD_LOADC, DATA_WORDS - 1);
    send_instr(CMD_LOADC, 32'hDEAD_BEEF);
    send_instr(CMD_STORE, 32'h0);
    send_instr(CMD_LOAD, 32'h0);
    send_instr(CMD_LOADC, DATA_WORDS);
    send_instr(CMD_LOAD, 32'h0);
    send_instr(CMD_LOADC, 32'hFFFF_FFFF);
    send_instr(CMD_LOAD, 32'h0);
    send_instr(CMD_LOADC, 32'h1);
    send_instr(CMD_STORE, 32'h0);
  endtask

  task automatic test_jumps();
    send_instr(CMD_JUMP, PROGRAM_WORDS);
    send_instr(CMD_JUMP, 32'h8000_0000);
    send_instr(CMD_JUMP, PROGRAM_WORDS - 1);
    send_instr(CMD_LAST_CODE, 32'h0);
    send_instr(CMD_JUMPZ, 32'd2000);
    send_instr(CMD_LOADC, 32'h0);
    send_instr(CMD_JUMPZ, 32'd2000);
    send_instr(CMD_JUMPZ, 32'd7);
    wait_results_done();
  endtask

  task automatic test_random_traffic(input int idle, input int stall);
    int first;
    idle_pct  = idle;
    stall_pct <= stall;
    first = instr_count;
    while (instr_count - first < RANDOM_ITEMS) send_sequence();
    wait_results_done();
  endtask

  // Push-heavy traffic to reach the full stack and overflow it
  task automatic test_stack_fill();
    int r;
    idle_pct  = 0;
    stall_pct <= 20;
    repeat (FILL_ITEMS) begin
      r = $urandom_range(99);
      if (r < 80) send_instr(CMD_LOADC, rand_word());
      else if (r < 90) send_instr(CMD_W'($urandom_range(CMD_ADD, CMD_EQUAL)), rand_word());
      else send_instr(CMD_PRINT, rand_word());
    end
    while (shadow_count > 8) send_instr(CMD_POP, rand_word());
    wait_results_done();
  endtask

  // Hold off the result side while instructions keep coming, then pause and repeat
  task automatic test_backpressure();
    int first;
    idle_pct  = 0;
    stall_pct <= 0;
    repeat (2) begin
      -> holdoff_start;
      first = instr_count;
      while (instr_count - first < 60) send_sequence();
      wait_results_done();
    end
  endtask

  // Exit, then everything after it must report halted
  task automatic test_exit_halt();
    logic [CMD_W-1:0] cmd;
    idle_pct  = 30;
    stall_pct <= 30;
    send_instr(CMD_EXIT, rand_word());
    repeat (16) begin
      cmd = CMD_W'($urandom_range(CMD_LAST_CODE));
      send_instr(cmd, rand_word());
    end
    wait_results_done();
  endtask

  task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    exec_result_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result: expected none, actual next_pc %h fault %h",
                   $time, out_next_pc, out_fault);
      end else begin
        want = pending_results.pop_front();
        check_field("next_pc", WORD_W'(want.next_pc), WORD_W'(out_next_pc));
        check_field("print_valid", WORD_W'(want.print_valid), WORD_W'(out_print_valid));
        check_field("print_value", want.print_value, out_print_value);
        check_field("halted", WORD_W'(want.halted), WORD_W'(out_halted));
        check_field("fault", WORD_W'(want.fault), WORD_W'(out_fault));
      end
    end
  end

  // Drive result-side stall: random, or held high during a hold-off
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= holding_off || ($urandom_range(99) < stall_pct);
  end

  // Count out the hold-off stretch
  always begin
    @(holdoff_start);
    holding_off <= 1'b1;
    repeat (HOLDOFF_CYCLES) @(posedge clk);
    holding_off <= 1'b0;
  end

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** stack_machine_execute_top: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    foreach (shadow_dmem[i]) shadow_dmem[i] = '0;
    foreach (shadow_stack[i]) shadow_stack[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_stack_faults();
    test_alu_ops();
    test_memory_access();
    test_jumps();
    test_random_traffic(0, 0);
    test_random_traffic(80, 0);
    test_random_traffic(0, 80);
    test_random_traffic(38, 38);
    test_stack_fill();
    test_backpressure();
    test_exit_halt();

    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) errors++;
    if (errors == 0) begin
      $display("** stack_machine_execute_top: PASSED **");
    end else begin
      $display("** stack_machine_execute_top: FAILED **");
    end
    $finish;
  end

endmodule
